FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, clocked on clk and held off
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: rtl/bsdf_pkg.sv
// ----------------------------------------------------------------------------
// bsdf_pkg
// Types and constants shared by the byte split delta filter modules.
// ----------------------------------------------------------------------------
package bsdf_pkg;

  // Operation codes of an input beat.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Filter direction.
  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // Delta bias.
  localparam logic [7:0] BIAS = 8'd128;

  // Configuration port: byte address width and register index.
  localparam int          CFG_AW        = 3;
  localparam logic [0:0]  REG_DIRECTION = 1'b0;

  // Queue between the front and back parts.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Input beat.
  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;
  } bsdf_in_t;

  // Result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    logic [1:0] status;
  } bsdf_out_t;

  // Classification of one fetch, decided by the front part.
  typedef struct packed {
    logic empty;      // nothing to emit
    logic first;      // first byte of the block
    logic zero_prev;  // no encode fetch since the last load
    logic is_final;   // final byte of the block
    logic trunc;      // block was truncated
    logic enc;        // encode direction
  } bsdf_tag_t;

  // Queue entry: classification plus the byte read from the store.
  typedef struct packed {
    bsdf_tag_t  tag;
    logic [7:0] data;
  } bsdf_cmd_t;

endpackage

FILE: rtl/bsdf_ram.sv
// ----------------------------------------------------------------------------
// bsdf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bsdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bsdf_front.sv
// ----------------------------------------------------------------------------
// bsdf_front
// Accepts input beats, writes loaded bytes into the block store, tracks the
// block counters and issues store reads for fetches, which it classifies and
// pushes into the queue together with the read byte.
// ----------------------------------------------------------------------------
module bsdf_front #(
  parameter int MAX_BYTES = 16384
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bsdf_pkg::bsdf_in_t           in_data,
  input  logic                         dir,
  input  logic                         q_room2,
  output logic                         ram_we,
  output logic [$clog2(MAX_BYTES)-1:0] ram_waddr,
  output logic [7:0]                   ram_wdata,
  output logic                         ram_re,
  output logic [$clog2(MAX_BYTES)-1:0] ram_raddr,
  input  logic [7:0]                   ram_rdata,
  output logic                         push,
  output bsdf_pkg::bsdf_cmd_t          push_cmd
);

  import bsdf_pkg::*;

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int AW = $clog2(MAX_BYTES);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_BYTES);

  logic [CW-1:0] load_count_r, load_count_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic          ready_r, ready_nxt;
  logic          trunc_r, trunc_nxt;
  logic          seen_r, seen_nxt;
  logic [7:0]    lrun_r, lrun_nxt;
  logic          pend_r, pend_nxt;
  bsdf_tag_t     tag_r, tag_nxt;

  logic          acc, is_load, is_fetch;
  logic [CW-1:0] base_cnt;
  logic          base_trunc, fits;
  logic [7:0]    v;
  logic [CW:0]   cnt_p1;
  logic [CW-1:0] half, k_minus, src, emit_inc;
  logic          empty, fin;

  assign in_ready = q_room2;
  assign acc      = in_valid & in_ready;
  assign is_load  = acc & (in_data.operation == OP_LOAD);
  assign is_fetch = acc & (in_data.operation == OP_FETCH);

  // Load path: a load onto a ready block starts a new block.
  always_comb begin
    base_cnt   = ready_r ? '0 : load_count_r;
    base_trunc = ready_r ? 1'b0 : trunc_r;
    fits       = base_cnt < MAX_C;
    if (dir == DIR_DEC && base_cnt != '0) begin
      v = lrun_r + in_data.data_byte + BIAS;
    end else begin
      v = in_data.data_byte;
    end
  end

  assign ram_we    = is_load & fits;
  assign ram_waddr = base_cnt[AW-1:0];
  assign ram_wdata = v;

  // Fetch path: source address of the next output byte.
  always_comb begin
    cnt_p1   = {1'b0, load_count_r} + (CW+1)'(1);
    half     = cnt_p1[CW:1];
    k_minus  = emit_r - half;
    emit_inc = emit_r + CW'(1);
    if (dir == DIR_ENC) begin
      if (emit_r < half) begin
        src = {emit_r[CW-2:0], 1'b0};
      end else begin
        src = {k_minus[CW-2:0], 1'b1};
      end
    end else begin
      if (emit_r[0] == 1'b0) begin
        src = emit_r >> 1;
      end else begin
        src = half + (emit_r >> 1);
      end
    end
    empty = !ready_r || (load_count_r == '0) || (emit_r >= load_count_r);
    fin   = emit_inc == load_count_r;
  end

  assign ram_re    = is_fetch & ~empty;
  assign ram_raddr = src[AW-1:0];

  // Block state update.
  always_comb begin
    load_count_nxt = load_count_r;
    emit_nxt       = emit_r;
    ready_nxt      = ready_r;
    trunc_nxt      = trunc_r;
    seen_nxt       = seen_r;
    lrun_nxt       = lrun_r;
    if (is_load) begin
      load_count_nxt = base_cnt + CW'(fits);
      trunc_nxt      = base_trunc | ~fits;
      emit_nxt       = '0;
      ready_nxt      = in_data.last_byte;
      seen_nxt       = 1'b0;
      lrun_nxt       = fits ? v : lrun_r;
    end else if (is_fetch && !empty) begin
      if (fin) begin
        load_count_nxt = '0;
        emit_nxt       = '0;
        ready_nxt      = 1'b0;
        trunc_nxt      = 1'b0;
      end else begin
        emit_nxt = emit_inc;
      end
      if (dir == DIR_ENC) begin
        seen_nxt = 1'b1;
      end
    end
  end

  // Classification registered while the store read completes.
  always_comb begin
    pend_nxt          = is_fetch;
    tag_nxt.empty     = empty;
    tag_nxt.first     = emit_r == '0;
    tag_nxt.zero_prev = ~seen_r;
    tag_nxt.is_final  = fin;
    tag_nxt.trunc     = trunc_r;
    tag_nxt.enc       = dir == DIR_ENC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      emit_r       <= '0;
      ready_r      <= 1'b0;
      trunc_r      <= 1'b0;
      seen_r       <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      load_count_r <= load_count_nxt;
      emit_r       <= emit_nxt;
      ready_r      <= ready_nxt;
      trunc_r      <= trunc_nxt;
      seen_r       <= seen_nxt;
      pend_r       <= pend_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    lrun_r <= lrun_nxt;
    tag_r  <= tag_nxt;
  end

  assign push          = pend_r;
  assign push_cmd.tag  = tag_r;
  assign push_cmd.data = ram_rdata;

endmodule

FILE: rtl/bsdf_fifo.sv
// ----------------------------------------------------------------------------
// bsdf_fifo
// Short queue of classified fetches between the front and back parts.
// ----------------------------------------------------------------------------
module bsdf_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bsdf_pkg::bsdf_cmd_t push_cmd,
  input  logic                pop,
  output logic                head_valid,
  output bsdf_pkg::bsdf_cmd_t head_cmd,
  output logic                room2
);

  import bsdf_pkg::*;

  bsdf_cmd_t       slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, wr_nxt;
  logic [Q_AW-1:0] rd_r, rd_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = push ? wr_r + Q_AW'(1) : wr_r;
    rd_nxt  = pop ? rd_r + Q_AW'(1) : rd_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

  assign head_valid = cnt_r != '0;
  assign head_cmd   = slot_r[rd_r];
  // Room for the beat in flight plus one more.
  assign room2      = cnt_r <= (Q_AW+1)'(Q_DEPTH - 2);

endmodule

FILE: rtl/bsdf_back.sv
// ----------------------------------------------------------------------------
// bsdf_back
// Takes classified fetches from the queue, applies the encode delta and
// holds the result beat in the output register.
// ----------------------------------------------------------------------------
module bsdf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  bsdf_pkg::bsdf_cmd_t head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output bsdf_pkg::bsdf_out_t out_data
);

  import bsdf_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  bsdf_out_t  out_r, out_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] base, value;

  assign pop = head_valid & (~out_valid_r | out_ready);

  // Result value: delta against the previous reordered byte in encode mode.
  always_comb begin
    base = head_cmd.tag.zero_prev ? 8'd0 : prev_r;
    if (head_cmd.tag.enc && !head_cmd.tag.first) begin
      value = head_cmd.data - base + BIAS;
    end else begin
      value = head_cmd.data;
    end
  end

  // Output register and running byte update.
  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    out_nxt       = out_r;
    prev_nxt      = prev_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      if (head_cmd.tag.empty) begin
        out_nxt.out_byte = 8'd0;
        out_nxt.last_out = 1'b0;
        out_nxt.status   = ST_EMPTY;
      end else begin
        out_nxt.out_byte = value;
        out_nxt.last_out = head_cmd.tag.is_final;
        out_nxt.status   = head_cmd.tag.trunc ? ST_TRUNC : ST_OK;
        if (head_cmd.tag.enc) begin
          prev_nxt = head_cmd.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    prev_r <= prev_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/byte_split_delta_filter.sv
// ----------------------------------------------------------------------------
// byte_split_delta_filter
// Reversible byte reorder and delta filter for image blocks. Encode splits a
// block into even then odd bytes and sends deltas; decode rebuilds bytes as
// they load and re-interleaves the two halves on fetch.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   bsdf_in_t (operation, byte, last)
//   out_     output     out_valid / out_ready bsdf_out_t (byte, last, status)
//   cfg      APB        psel/penable/pready   direction at address 0
//
// A load or a fetch is accepted every cycle while the queue has room; a load
// writes the block store in its accept cycle and produces no beat.
// A fetch beat passes through the registered store read, the queue and the
// output register, and an output stall can hold it in the queue.
// The four-entry queue absorbs output stalls; in_ready drops once it is
// nearly full. Reset is synchronous and needs no clearing pass of the store.
// ----------------------------------------------------------------------------
module byte_split_delta_filter #(
  parameter int MAX_BYTES = 16384
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  bsdf_pkg::bsdf_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output bsdf_pkg::bsdf_out_t                out_data,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bsdf_pkg::CFG_AW-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import bsdf_pkg::*;

  localparam int AW = $clog2(MAX_BYTES);

  logic          dir_r, dir_nxt;
  logic          reg_hit;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          push, pop, head_valid, room2;
  bsdf_cmd_t     push_cmd, head_cmd;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_hit = paddr[CFG_AW-1:2] == REG_DIRECTION;
  assign dir_nxt = (psel && penable && pwrite && reg_hit) ? pwdata[0] : dir_r;
  assign prdata  = reg_hit ? {31'd0, dir_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_ENC;
    end else begin
      dir_r <= dir_nxt;
    end
  end

  // Front part: accept, load and classify.
  bsdf_front #(
    .MAX_BYTES(MAX_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dir      (dir_r),
    .q_room2  (room2),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Block store.
  bsdf_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Queue between the two parts.
  bsdf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .room2     (room2)
  );

  // Back part: delta and output register.
  bsdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/bsdf_checker.sv
// ----------------------------------------------------------------------------
// bsdf_checker
// Port-level checks on the byte split delta filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsdf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input bsdf_pkg::bsdf_out_t         out_data,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [bsdf_pkg::CFG_AW-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata,
  input logic                        pready
);

  import bsdf_pkg::*;

  // The register port never inserts wait states.
  `ASSERT_SAME(a_pready_high, 1'b1, pready)

  // A stalled result beat holds its payload.
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // A direction write reads back on the next cycle.
  `ASSERT_NEXT(a_dir_readback, psel && penable && pwrite && paddr[CFG_AW-1:2] == REG_DIRECTION, prdata == {31'd0, $past(pwdata[0])})

  // A beat with nothing to emit carries a zero byte and no end mark.
  `ASSERT_SAME(a_empty_shape, out_valid && out_data.status == ST_EMPTY, out_data.out_byte == 8'd0 && !out_data.last_out)

  // Status never takes the unused code.
  `ASSERT_SAME(a_status_code, out_valid, out_data.status == ST_OK || out_data.status == ST_EMPTY || out_data.status == ST_TRUNC)

endmodule

bind byte_split_delta_filter bsdf_checker u_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .pready   (pready)
);

FILE: dv/byte_split_delta_filter_test.sv
// ----------------------------------------------------------------------------
// byte_split_delta_filter_test
// Self-checking testbench for the byte split delta filter. The testbench
// drives load and fetch beats through the valid/ready input channel and sets
// the direction over the APB port. A scoreboard keeps its own copy of the
// block store and predicts every fetch result, and each output beat is
// compared field by field.
// The stimulus has a directed opening and then random phases of well-formed
// blocks mixed with stray beats. A direction change lands between phases,
// sometimes in the middle of a block.
// ----------------------------------------------------------------------------
module byte_split_delta_filter_test;
  import bsdf_pkg::*;

  localparam int BLOCK_CAP      = 16384;
  localparam int CLK_HALF       = 6;
  localparam int RANDOM_ITEMS   = 1300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int TIMEOUT_CYCLES = 2000000;
  localparam int PRINT_LIMIT    = 100;
  localparam logic [CFG_AW-1:0] DIR_ADDR = CFG_AW'(4 * REG_DIRECTION);

  logic               clk;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  bsdf_in_t           in_data  = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bsdf_out_t          out_data;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [CFG_AW-1:0]  paddr    = '0;
  logic [31:0]        pwdata   = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Predicts the filtered or restored bytes and checks the output beats.
  class split_delta_scoreboard;
    logic [7:0]  block_bytes [BLOCK_CAP];
    int unsigned fill_count;
    int unsigned emit_pos;
    logic [7:0]  prev_byte;
    bit          ready_flag;
    bit          trunc_flag;
    logic        dir;
    bsdf_out_t   awaited_beats [$];
    int          fail_count;

    function void clear_block();
      fill_count = 0;
      emit_pos   = 0;
      prev_byte  = '0;
      ready_flag = 1'b0;
      trunc_flag = 1'b0;
    endfunction

    function new();
      clear_block();
      dir        = DIR_ENC;
      fail_count = 0;
    endfunction

    task report(string msg);
      if (fail_count < PRINT_LIMIT) begin
        $display("[%0t] filter check: %s", $time, msg);
      end
      fail_count++;
    endtask

    // A load after a finished block starts a new one; decode rebuilds as it loads.
    function void store_loaded_byte(logic [7:0] data, logic last);
      logic [7:0] v;
      if (ready_flag) begin
        clear_block();
      end
      if (fill_count < BLOCK_CAP) begin
        v = data;
        if (dir == DIR_DEC && fill_count > 0) begin
          v = prev_byte + data + BIAS;
        end
        block_bytes[fill_count] = v;
        prev_byte = v;
        fill_count++;
      end else begin
        trunc_flag = 1'b1;
      end
      if (last) begin
        ready_flag = 1'b1;
        emit_pos   = 0;
        prev_byte  = '0;
      end
    endfunction

    // Encode walks even bytes then odd bytes as deltas; decode re-interleaves.
    function bsdf_out_t filtered_beat();
      bsdf_out_t   r;
      int unsigned half;
      int unsigned src;
      logic [7:0]  cur;
      r = '0;
      if (!ready_flag || fill_count == 0 || emit_pos >= fill_count) begin
        r.status = ST_EMPTY;
        return r;
      end
      half = (fill_count + 1) / 2;
      if (dir == DIR_ENC) begin
        src = (emit_pos < half) ? 2 * emit_pos : 2 * (emit_pos - half) + 1;
        cur = block_bytes[src];
        r.out_byte = (emit_pos == 0) ? cur : cur - prev_byte + BIAS;
        prev_byte = cur;
      end else begin
        src = (emit_pos[0] == 1'b0) ? emit_pos / 2 : half + emit_pos / 2;
        r.out_byte = block_bytes[src];
      end
      r.last_out = (emit_pos + 1 == fill_count);
      r.status   = trunc_flag ? ST_TRUNC : ST_OK;
      if (r.last_out) begin
        clear_block();
      end else begin
        emit_pos++;
      end
      return r;
    endfunction

    function void note_input(bsdf_in_t beat);
      if (beat.operation == OP_LOAD) begin
        store_loaded_byte(beat.data_byte, beat.last_byte);
      end else begin
        awaited_beats.push_back(filtered_beat());
      end
    endfunction

    task check_output(bsdf_out_t got);
      bsdf_out_t want;
      if (awaited_beats.size() == 0) begin
        report($sformatf("output beat %h with nothing expected", got));
        return;
      end
      want = awaited_beats.pop_front();
      if (got.out_byte !== want.out_byte) begin
        report($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
      end
      if (got.last_out !== want.last_out) begin
        report($sformatf("last_out got %b want %b", got.last_out, want.last_out));
      end
      if (got.status !== want.status) begin
        report($sformatf("status got %0d want %0d", got.status, want.status));
      end
    endtask
  endclass

  split_delta_scoreboard filter_sb;
  int burst_left = 0;
  bit gaps_on    = 1'b1;
  int items_sent = 0;

  byte_split_delta_filter #(
    .MAX_BYTES (BLOCK_CAP)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Give up if the run hangs.
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("byte_split_delta_filter_test: FAIL");
    $finish;
  end

  // The receiver stalls following a random eight-bit ready mask that repeats and is redrawn in turn.
  initial begin
    logic [7:0] stall_mask;
    int         idx;
    idx = 0;
    forever begin
      stall_mask = 8'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        stall_mask = 8'hFF;
      end
      stall_mask[0] = 1'b1;
      repeat (64) begin
        @(posedge clk);
        out_ready <= stall_mask[idx % 8];
        idx++;
      end
    end
  end

  // Every accepted output beat goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      filter_sb.check_output(out_data);
    end
  end

  // Drives one beat and returns at the edge that accepts it; valid stays high.
  task automatic send_beat(input bsdf_in_t beat);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    filter_sb.note_input(beat);
    items_sent++;
  endtask

  // Stops sending until every expected beat has come back or the drain limit is reached.
  task automatic hold_until_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (filter_sb.awaited_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the direction register, then reads it back.
  task automatic set_direction(input logic dir);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIR_ADDR;
    pwdata  <= 32'(dir);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    filter_sb.dir = dir;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== dir) begin
      filter_sb.report($sformatf("direction read back %b want %b", prdata[0], dir));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return 8'($urandom);
  endfunction

  // Fetch beats carry random filler in the ignored fields.
  task automatic fetch_beats(input int count);
    for (int i = 0; i < count; i++) begin
      send_beat({OP_FETCH, 8'($urandom), 1'($urandom)});
    end
  endtask

  task automatic load_block(input int len, input int fetches);
    for (int i = 0; i < len; i++) begin
      send_beat({OP_LOAD, pick_byte(), logic'(i == len - 1)});
    end
    fetch_beats(fetches);
  endtask

  initial begin
    int budget;
    int len;
    int fetches;
    int pick;
    filter_sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty fetch, odd and even blocks, discarded block.
    set_direction(DIR_ENC);
    fetch_beats(1);
    send_beat({OP_LOAD, 8'h00, 1'b0});
    send_beat({OP_LOAD, 8'hFF, 1'b0});
    send_beat({OP_LOAD, 8'h80, 1'b0});
    send_beat({OP_LOAD, 8'h01, 1'b0});
    send_beat({OP_LOAD, 8'h7F, 1'b1});
    fetch_beats(5);
    send_beat({OP_LOAD, 8'hAA, 1'b1});
    fetch_beats(2);
    send_beat({OP_LOAD, 8'h33, 1'b0});
    send_beat({OP_LOAD, 8'hCC, 1'b1});
    send_beat({OP_LOAD, 8'h5A, 1'b1});
    fetch_beats(1);
    hold_until_drained();
    set_direction(DIR_DEC);
    send_beat({OP_LOAD, 8'h10, 1'b0});
    send_beat({OP_LOAD, 8'h00, 1'b0});
    send_beat({OP_LOAD, 8'hFF, 1'b0});
    send_beat({OP_LOAD, 8'h80, 1'b1});
    fetch_beats(4);

    // Random phases; each one starts with the output drained and a newly chosen direction.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      hold_until_drained();
      set_direction($urandom_range(0, 1) ? DIR_DEC : DIR_ENC);
      gaps_on = ($urandom_range(0, 3) != 0);
      // Finish part of a block left over from the previous direction.
      if (filter_sb.ready_flag && $urandom_range(0, 1) == 1) begin
        fetch_beats($urandom_range(1, filter_sb.fill_count - filter_sb.emit_pos));
      end
      budget = items_sent + $urandom_range(60, 160);
      while (items_sent < budget) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
          case ($urandom_range(0, 7))
            0: fetches = len + $urandom_range(1, 2);
            1: fetches = $urandom_range(0, len - 1);
            default: fetches = len;
          endcase
          load_block(len, fetches);
        end else if (pick < 9) begin
          repeat ($urandom_range(1, 4)) begin
            send_beat({($urandom_range(0, 1) ? OP_FETCH : OP_LOAD), pick_byte(),
                       logic'($urandom_range(0, 3) == 0)});
          end
        end else begin
          // Leave a block open so that it may continue under the next direction.
          repeat ($urandom_range(1, 5)) send_beat({OP_LOAD, pick_byte(), 1'b0});
        end
      end
    end

    hold_until_drained();
    if (filter_sb.awaited_beats.size() != 0) begin
      filter_sb.report($sformatf("%0d beats still expected at end of run",
                                 filter_sb.awaited_beats.size()));
    end
    if (filter_sb.fail_count == 0) begin
      $display("byte_split_delta_filter_test: PASS");
    end else begin
      $display("byte_split_delta_filter_test: FAIL");
    end
    $finish;
  end

endmodule
